// ----- rtl/joint_admittance_integrator_core_assert.svh -----
// Assertion macros for the joint admittance integrator core.
// Clocked on clk_i and disabled while rst_ni is low; used by the top level.
`ifndef JOINT_ADMITTANCE_INTEGRATOR_CORE_ASSERT_SVH
`define JOINT_ADMITTANCE_INTEGRATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define JAI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define JAI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JAI_ASSERT_IMPL(lbl, ante, cons, msg)
`define JAI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/jai_pkg.sv -----
// Shared types, widths and helpers of the joint admittance integrator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jai_pkg;

  localparam int unsigned JOINT_W   = 3;
  localparam int unsigned POS_W     = 20;
  localparam int unsigned VEL_W     = 18;
  localparam int unsigned TRQ_W     = 16;
  localparam int unsigned COEF_W    = 10;
  localparam int unsigned PACK_W    = 60;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DT_W-1:0]         DT_RESET = 16'd655;
  // pi in Q3.16
  localparam logic signed [POS_W-1:0] PI_Q16   = 20'sd205887;

  typedef enum logic [OP_W-1:0] {
    OP_SET_VEL  = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_LOAD_POS = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_MASS  = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_VEL_LIMIT = 3'd2,
    REG_ACC_LIMIT = 3'd3,
    REG_TIME_STEP = 3'd4
  } cfg_reg_e;

  // One joint's stored state
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [VEL_W-1:0] vel;
  } entry_t;

  // Per-joint coefficients picked out of the packs
  typedef struct packed {
    logic [COEF_W-1:0] inv_mass;
    logic [COEF_W-1:0] damping;
    logic [COEF_W-1:0] vel_lim;
    logic [COEF_W-1:0] acc_lim;
  } coef_t;

  // Datapath result and status
  typedef struct packed {
    logic                    done;
    logic                    oob;
    logic signed [POS_W-1:0] pos;
    logic signed [VEL_W-1:0] vel;
  } dp_res_t;

  // Pick the 10-bit field of joint j out of a pack
  function automatic logic [COEF_W-1:0] field10(input logic [PACK_W-1:0] pack,
                                                input logic [JOINT_W-1:0] j);
    logic [COEF_W-1:0] f;
    unique case (j)
      3'd0:    f = pack[0*COEF_W +: COEF_W];
      3'd1:    f = pack[1*COEF_W +: COEF_W];
      3'd2:    f = pack[2*COEF_W +: COEF_W];
      3'd3:    f = pack[3*COEF_W +: COEF_W];
      3'd4:    f = pack[4*COEF_W +: COEF_W];
      3'd5:    f = pack[5*COEF_W +: COEF_W];
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/jai_state_mem.sv -----
// Joint state memory: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero; uses jai_pkg.
`timescale 1ns / 1ps

module jai_state_mem #(
  parameter int unsigned Depth = 6,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output jai_pkg::entry_t  rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  jai_pkg::entry_t  wr_data_i
);
  import jai_pkg::*;

  entry_t           mem_q [Depth];
  logic [Depth-1:0] valid_q;
  entry_t           rd_q;
  logic             rd_valid_q;

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Mark written entries; reset clears all marks at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ----- rtl/jai_update_dp.sv -----
// Update-step datapath: acceleration, velocity and position in six
// register stages, four multiplies each followed by a register. Uses jai_pkg.
`timescale 1ns / 1ps

module jai_update_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [jai_pkg::TRQ_W-1:0]   torque_i,
  input  jai_pkg::entry_t                    entry_i,
  input  jai_pkg::coef_t                     coef_i,
  input  logic        [jai_pkg::DT_W-1:0]    dt_i,
  output jai_pkg::dp_res_t                   res_o
);
  import jai_pkg::*;

  localparam int unsigned Stages = 6;
  localparam int unsigned ProdAW = TRQ_W + COEF_W + 1;
  localparam int unsigned ProdBW = VEL_W + COEF_W + 1;
  localparam int unsigned AccW   = 32;
  localparam int unsigned AccQW  = 23;
  localparam int unsigned DvW    = AccQW + DT_W + 1;
  localparam int unsigned DpW    = VEL_W + DT_W + 1;
  localparam int unsigned VsumW  = VEL_W + 2;
  localparam int unsigned DpOutW = VEL_W + 1;
  localparam int unsigned PsumW  = POS_W + 1;

  localparam logic signed [DvW-1:0]   DvRound = DvW'(1) <<< 21;
  localparam logic signed [DpW-1:0]   DpRound = DpW'(1) <<< 15;
  localparam logic signed [PsumW-1:0] PosMax  = PsumW'((1 << (POS_W - 1)) - 1);
  localparam logic signed [PsumW-1:0] PosMin  = -PsumW'(1 << (POS_W - 1));

  logic [Stages-1:0] stage_q;

  logic signed [DT_W:0]       dt_s;
  logic signed [COEF_W:0]     im_s;
  logic signed [COEF_W:0]     dr_s;

  logic signed [ProdAW-1:0]   prod_a_d, prod_a_q;
  logic signed [ProdBW-1:0]   prod_b_d, prod_b_q;
  logic signed [VEL_W-1:0]    vel_q;
  logic signed [POS_W-1:0]    pos_q;

  logic signed [AccW-1:0]     acc_raw, alim_s, acc_c;
  logic signed [AccQW-1:0]    acc_d, acc_q;

  logic signed [DvW-1:0]      dvprod_d, dvprod_q, dv_sum;
  logic signed [VEL_W-1:0]    dv;
  logic signed [VsumW-1:0]    vsum, vlim_s, vclamp;
  logic signed [VEL_W-1:0]    vnew_d, vnew_q;

  logic signed [DpW-1:0]      dpprod_d, dpprod_q, dp_sum;
  logic signed [DpOutW-1:0]   dp;
  logic signed [PsumW-1:0]    psum;
  logic signed [POS_W-1:0]    pnew_d, pnew_q;
  logic                       oob_d, oob_q;

  // Advance the stage marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[Stages-2:0], start_i};
    end
  end

  // Stage 0: force and damping products
  always_comb begin
    dt_s     = {1'b0, dt_i};
    im_s     = {1'b0, coef_i.inv_mass};
    dr_s     = {1'b0, coef_i.damping};
    prod_a_d = torque_i * im_s;
    prod_b_d = entry_i.vel * dr_s;
  end

  // Stage 1: acceleration in Q.22, clamped to the limit
  always_comb begin
    acc_raw = (AccW'(prod_a_q) <<< 4) - AccW'(prod_b_q);
    alim_s  = AccW'({coef_i.acc_lim, 12'b0});
    priority if (acc_raw > alim_s) begin
      acc_c = alim_s;
    end else if (acc_raw < -alim_s) begin
      acc_c = -alim_s;
    end else begin
      acc_c = acc_raw;
    end
    acc_d = acc_c[AccQW-1:0];
  end

  // Stage 2: velocity change product
  assign dvprod_d = acc_q * dt_s;

  // Stage 3: round, add and clamp the velocity
  always_comb begin
    dv_sum = dvprod_q + DvRound;
    dv     = dv_sum[22 +: VEL_W];
    vsum   = VsumW'(vel_q) + VsumW'(dv);
    vlim_s = VsumW'({coef_i.vel_lim, 6'b0});
    priority if (vsum > vlim_s) begin
      vclamp = vlim_s;
    end else if (vsum < -vlim_s) begin
      vclamp = -vlim_s;
    end else begin
      vclamp = vsum;
    end
    vnew_d = vclamp[VEL_W-1:0];
  end

  // Stage 4: position change product
  assign dpprod_d = vnew_q * dt_s;

  // Stage 5: round, add, saturate and check the bound
  always_comb begin
    dp_sum = dpprod_q + DpRound;
    dp     = dp_sum[16 +: DpOutW];
    psum   = PsumW'(pos_q) + PsumW'(dp);
    priority if (psum > PosMax) begin
      pnew_d = PosMax[POS_W-1:0];
    end else if (psum < PosMin) begin
      pnew_d = PosMin[POS_W-1:0];
    end else begin
      pnew_d = psum[POS_W-1:0];
    end
    oob_d = (pnew_d > PI_Q16) || (pnew_d < -PI_Q16);
  end

  // Hold each stage's result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
      vel_q    <= entry_i.vel;
      pos_q    <= entry_i.pos;
    end
    if (stage_q[0]) begin
      acc_q <= acc_d;
    end
    if (stage_q[1]) begin
      dvprod_q <= dvprod_d;
    end
    if (stage_q[2]) begin
      vnew_q <= vnew_d;
    end
    if (stage_q[3]) begin
      dpprod_q <= dpprod_d;
    end
    if (stage_q[4]) begin
      pnew_q <= pnew_d;
      oob_q  <= oob_d;
    end
  end

  assign res_o.done = stage_q[Stages-1];
  assign res_o.oob  = oob_q;
  assign res_o.pos  = pnew_q;
  assign res_o.vel  = vnew_q;

endmodule

// ----- rtl/joint_admittance_integrator_core.sv -----
// Top level of the per-joint mass-damper admittance integrator.
// Holds configuration, the item sequencer and the output register;
// uses jai_pkg, jai_state_mem, jai_update_dp and the assertion header.
//
//   Channel  Handshake                   Payload
//   in       in_valid_i / in_ready_o     operation, joint, torque, measured_velocity,
//                                        initial_position
//   out      out_valid_o / out_ready_i   joint_out, position, velocity, fault
//   cfg      cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// One item at a time. An update step runs a memory read, the datapath's register stages
// (four multiplies), a write-back and a return to idle before the next item is accepted;
// other items skip the datapath.
// Reset clears all joint state through the memory's valid bits: no clearing pass.
// A result waits in the output register; write-back holds while it is not taken.
`timescale 1ns / 1ps
`include "joint_admittance_integrator_core_assert.svh"

module joint_admittance_integrator_core #(
  parameter int unsigned JOINTS = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [jai_pkg::OP_W-1:0]       operation_i,
  input  logic        [jai_pkg::JOINT_W-1:0]    joint_i,
  input  logic signed [jai_pkg::TRQ_W-1:0]      torque_i,
  input  logic signed [jai_pkg::VEL_W-1:0]      measured_velocity_i,
  input  logic signed [jai_pkg::POS_W-1:0]      initial_position_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [jai_pkg::JOINT_W-1:0]    joint_out_o,
  output logic signed [jai_pkg::POS_W-1:0]      position_o,
  output logic signed [jai_pkg::VEL_W-1:0]      velocity_o,
  output logic                                  fault_o,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic        [jai_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [jai_pkg::PACK_W-1:0]     cfg_data_i
);
  import jai_pkg::*;

  localparam int unsigned AddrW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [JOINT_W-1:0] JointLim = JOINT_W'(JOINTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_WRITE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [PACK_W-1:0] inv_mass_q, damping_q, vel_limit_q, acc_limit_q;
  logic [DT_W-1:0]   time_step_q;

  // Item registers
  op_e                     item_op_q;
  logic [JOINT_W-1:0]      item_joint_q;
  logic signed [TRQ_W-1:0] item_torque_q;
  logic signed [VEL_W-1:0] item_mvel_q;
  logic signed [POS_W-1:0] item_ipos_q;

  // Result and output registers
  logic signed [POS_W-1:0] res_pos_q;
  logic signed [VEL_W-1:0] res_vel_q;
  logic                    res_wr_q;
  logic                    res_oob_q;
  logic                    fault_q;
  logic                    out_valid_q;
  logic [JOINT_W-1:0]      out_joint_q;
  logic signed [POS_W-1:0] out_pos_q;
  logic signed [VEL_W-1:0] out_vel_q;
  logic                    out_fault_q;

  logic    in_fire, rd_en, joint_ok, out_free, dp_start, mem_we, fault_next;
  entry_t  rd_entry, wr_entry;
  coef_t   coef;
  dp_res_t dp_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_en      = in_fire && (joint_i < JointLim);
  assign joint_ok   = (item_joint_q < JointLim);
  assign out_free   = !out_valid_q || out_ready_i;
  assign dp_start   = (state_q == S_READ) && joint_ok && (item_op_q == OP_UPDATE) && !fault_q;
  assign mem_we     = (state_q == S_WRITE) && out_free && res_wr_q;
  assign fault_next = fault_q || res_oob_q;
  assign wr_entry   = '{pos: res_pos_q, vel: res_vel_q};

  // Pick the joint's coefficients
  always_comb begin
    coef.inv_mass = field10(inv_mass_q, item_joint_q);
    coef.damping  = field10(damping_q, item_joint_q);
    coef.vel_lim  = field10(vel_limit_q, item_joint_q);
    coef.acc_lim  = field10(acc_limit_q, item_joint_q);
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q  <= '0;
      damping_q   <= '0;
      vel_limit_q <= '0;
      acc_limit_q <= '0;
      time_step_q <= DT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INV_MASS:  inv_mass_q  <= cfg_data_i;
        REG_DAMPING:   damping_q   <= cfg_data_i;
        REG_VEL_LIMIT: vel_limit_q <= cfg_data_i;
        REG_ACC_LIMIT: acc_limit_q <= cfg_data_i;
        REG_TIME_STEP: time_step_q <= cfg_data_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_op_q     <= op_e'(operation_i);
      item_joint_q  <= joint_i;
      item_torque_q <= torque_i;
      item_mvel_q   <= measured_velocity_i;
      item_ipos_q   <= initial_position_i;
    end
  end

  jai_state_mem #(
    .Depth(JOINTS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (joint_i[AddrW-1:0]),
    .rd_data_o (rd_entry),
    .wr_en_i   (mem_we),
    .wr_addr_i (item_joint_q[AddrW-1:0]),
    .wr_data_i (wr_entry)
  );

  jai_update_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (dp_start),
    .torque_i (item_torque_q),
    .entry_i  (rd_entry),
    .coef_i   (coef),
    .dt_i     (time_step_q),
    .res_o    (dp_res)
  );

  // Sequence one item: read, compute (updates only), write back where needed and present the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_pos_q   <= '0;
      res_vel_q   <= '0;
      res_wr_q    <= 1'b0;
      res_oob_q   <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_joint_q <= '0;
      out_pos_q   <= '0;
      out_vel_q   <= '0;
      out_fault_q <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && (state_q != S_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          res_oob_q <= 1'b0;
          priority if (dp_start) begin
            state_q <= S_CALC;
          end else if (!joint_ok) begin
            res_pos_q <= '0;
            res_vel_q <= '0;
            res_wr_q  <= 1'b0;
            state_q   <= S_WRITE;
          end else begin
            unique case (item_op_q)
              OP_SET_VEL: begin
                res_pos_q <= rd_entry.pos;
                res_vel_q <= item_mvel_q;
                res_wr_q  <= 1'b1;
              end
              OP_LOAD_POS: begin
                res_pos_q <= item_ipos_q;
                res_vel_q <= rd_entry.vel;
                res_wr_q  <= 1'b1;
              end
              default: begin
                // update after a fault, or an unused operation code
                res_pos_q <= rd_entry.pos;
                res_vel_q <= rd_entry.vel;
                res_wr_q  <= 1'b0;
              end
            endcase
            state_q <= S_WRITE;
          end
        end
        S_CALC: begin
          if (dp_res.done) begin
            res_pos_q <= dp_res.pos;
            res_vel_q <= dp_res.vel;
            res_oob_q <= dp_res.oob;
            res_wr_q  <= 1'b1;
            state_q   <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            fault_q     <= fault_next;
            out_valid_q <= 1'b1;
            out_joint_q <= item_joint_q;
            out_pos_q   <= res_pos_q;
            out_vel_q   <= res_vel_q;
            out_fault_q <= fault_next;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign joint_out_o = out_joint_q;
  assign position_o  = out_pos_q;
  assign velocity_o  = out_vel_q;
  assign fault_o     = out_fault_q;

  // Checks
  `JAI_ASSERT_NEXT(a_fault_sticky, fault_q, fault_q, "bound fault cleared without reset")
  `JAI_ASSERT_IMPL(a_dp_done_in_calc, dp_res.done, state_q == S_CALC,
                   "datapath finished outside the compute state")
  `JAI_ASSERT_NEXT(a_no_write_after_accept, in_fire, !mem_we,
                   "memory written right after an item was accepted")
  `JAI_ASSERT_NEXT(a_bad_joint_zero, (state_q == S_WRITE) && out_free && !joint_ok,
                   (position_o == '0) && (velocity_o == '0),
                   "result for an absent joint is not zero")

endmodule
